// ----- hdl/scfp_pkg.sv -----
// scfp_pkg: shared types, constants and byte classifiers for the frame parser
// used by scfp_ctrl, scfp_dp and serial_command_frame_parser
`default_nettype none

package scfp_pkg;

	localparam int          LINE_DEPTH_DEFAULT = 64;
	localparam logic [15:0] START_WORD_RESET   = 16'hABCD;
	localparam logic [2:0]  FRAME_LAST_POS     = 3'd7;
	localparam logic [7:0]  CHAR_CR            = 8'h0D;
	localparam logic [7:0]  CHAR_LF            = 8'h0A;
	localparam logic [7:0]  CHAR_PRINT_LO      = 8'h20;
	localparam logic [7:0]  CHAR_PRINT_HI      = 8'h7E;
	localparam logic        KIND_FRAME         = 1'b0;
	localparam logic        KIND_LINE          = 1'b1;

	typedef struct packed {
		logic capture;
		logic held;
		logic main;
		logic load_char;
		logic load_nl;
		logic load_frame;
	} scfp_cmd_t;

	typedef struct packed {
		logic held_needed;
		logic held_emit;
		logic main_emit;
		logic frame_ok;
		logic out_free;
		logic last_char;
	} scfp_status_t;

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= CHAR_PRINT_LO) && (c <= CHAR_PRINT_HI);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/scfp_ctrl.sv -----
// scfp_ctrl: sequencer for one received item, line emission and frame result
// depends on scfp_pkg; drives scfp_dp through command and status structs
`default_nettype none

module scfp_ctrl
	import scfp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         rx_valid,
	output logic              rx_stall,
	input  wire scfp_status_t st,
	output scfp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MAIN,
		S_EMIT_RD,
		S_EMIT_WR,
		S_EMIT_NL,
		S_FRAME
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   resume_q;
	logic   resume_d;

	assign rx_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		resume_d = resume_q;
		unique case (state_q)
			S_IDLE: begin
				if (rx_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.held_needed) begin
					cmd.held = 1'b1;
					if (st.held_emit) begin
						resume_d = 1'b1;
						state_d  = S_EMIT_RD;
					end else begin
						state_d = S_MAIN;
					end
				end else begin
					cmd.main = 1'b1;
					resume_d = 1'b0;
					if (st.main_emit) state_d = S_EMIT_RD;
					else if (st.frame_ok) state_d = S_FRAME;
					else state_d = S_IDLE;
				end
			end
			S_MAIN: begin
				cmd.main = 1'b1;
				resume_d = 1'b0;
				if (st.main_emit) state_d = S_EMIT_RD;
				else if (st.frame_ok) state_d = S_FRAME;
				else state_d = S_IDLE;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (st.out_free) begin
					cmd.load_char = 1'b1;
					state_d = st.last_char ? S_EMIT_NL : S_EMIT_RD;
				end
			end
			S_EMIT_NL: begin
				if (st.out_free) begin
					cmd.load_nl = 1'b1;
					state_d = resume_q ? S_MAIN : S_IDLE;
				end
			end
			S_FRAME: begin
				if (st.out_free) begin
					cmd.load_frame = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			resume_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/scfp_dp.sv -----
// scfp_dp: frame byte registers, debug line memory, line walk and result register
// depends on scfp_pkg; sequenced by scfp_ctrl
`default_nettype none

module scfp_dp
	import scfp_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               cfg_write,
	input  wire logic [15:0]        cfg_data,
	input  wire scfp_cmd_t          cmd,
	output scfp_status_t            st,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    result_kind,
	output logic signed [15:0]      left_command,
	output logic signed [15:0]      right_command,
	output logic [7:0]              line_char,
	output logic                    line_last
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [AW-1:0] LEN_MAX = AW'(LINE_DEPTH - 1);

	logic [15:0]   start_word_q;
	logic [7:0]    byte_q;
	logic [7:0]    frame_q [8];
	logic [2:0]    pos_q;
	logic [AW-1:0] line_len_q;
	logic [AW-1:0] emit_len_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    line_mem [LINE_DEPTH];
	logic [7:0]    rd_data_q;

	logic          line_en;
	logic [7:0]    line_in;
	logic          main_hunt;
	logic [15:0]   s_word;
	logic [15:0]   l_word;
	logic [15:0]   r_word;
	logic [15:0]   c_word;
	logic          load_any;

	assign s_word = {frame_q[1], frame_q[0]};
	assign l_word = {frame_q[3], frame_q[2]};
	assign r_word = {frame_q[5], frame_q[4]};
	assign c_word = {byte_q, frame_q[6]};

	assign main_hunt = (pos_q == 3'd0) && (byte_q != start_word_q[7:0]);
	assign line_en   = cmd.held || (cmd.main && main_hunt);
	assign line_in   = cmd.held ? frame_q[0] : byte_q;
	assign load_any  = cmd.load_char || cmd.load_nl || cmd.load_frame;

	always_comb begin
		st.held_needed = (pos_q == 3'd1) && (byte_q != start_word_q[15:8]);
		st.held_emit   = is_eol(frame_q[0]) && (line_len_q != '0);
		st.main_emit   = main_hunt && is_eol(byte_q) && (line_len_q != '0);
		st.frame_ok    = (pos_q == FRAME_LAST_POS) && (s_word == start_word_q)
			&& (c_word == (s_word ^ l_word ^ r_word));
		st.out_free    = !result_valid || !result_stall;
		st.last_char   = (idx_q == emit_len_q - AW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_word_q <= START_WORD_RESET;
		end else if (cfg_write) begin
			start_word_q <= cfg_data;
		end
	end

	// frame position and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			line_len_q <= '0;
		end else begin
			if (cmd.held) begin
				pos_q <= '0;
			end else if (cmd.main) begin
				if (pos_q == 3'd0) begin
					if (!main_hunt) pos_q <= 3'd1;
				end else if (pos_q == FRAME_LAST_POS) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
			if (line_en) begin
				if (is_eol(line_in) || !is_print(line_in)) line_len_q <= '0;
				else if (line_len_q < LEN_MAX) line_len_q <= line_len_q + AW'(1);
				else line_len_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) byte_q <= rx_byte;
		if (cmd.main && !main_hunt) frame_q[pos_q] <= byte_q;
		if (line_en && is_eol(line_in) && (line_len_q != '0)) begin
			emit_len_q <= line_len_q;
			idx_q      <= '0;
		end else if (cmd.load_char) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (line_en && !is_eol(line_in) && is_print(line_in) && (line_len_q < LEN_MAX)) begin
			line_mem[line_len_q] <= line_in;
		end
		rd_data_q <= line_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_any) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char) begin
			result_kind   <= KIND_LINE;
			left_command  <= '0;
			right_command <= '0;
			line_char     <= rd_data_q;
			line_last     <= 1'b0;
		end else if (cmd.load_nl) begin
			result_kind   <= KIND_LINE;
			left_command  <= '0;
			right_command <= '0;
			line_char     <= CHAR_LF;
			line_last     <= 1'b1;
		end else if (cmd.load_frame) begin
			result_kind   <= KIND_FRAME;
			left_command  <= l_word;
			right_command <= r_word;
			line_char     <= '0;
			line_last     <= 1'b0;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LEN_MAX)
		else $error("line length beyond capacity");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.main && (pos_q == FRAME_LAST_POS)) |=> (pos_q == 3'd0))
		else $error("frame position did not wrap after last byte");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_any |-> (st.out_free && $onehot({cmd.load_char, cmd.load_nl, cmd.load_frame})))
		else $error("result register overwritten");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_char |-> (idx_q < emit_len_q))
		else $error("line walk past stored length");

endmodule

`default_nettype wire

// ----- hdl/serial_command_frame_parser.sv -----
// sequence: each received item is captured and then checked; a wrong second start byte
// is replayed through the main state, and a closing frame is loaded in the frame state
// a line adds a read state and a load state per character (through the single line
// memory port), then the newline; result stalls extend it
// reset: arst_n clears state machine, frame position, line length, start word
// and result valid; frame and line stores are not cleared
`default_nettype none

module serial_command_frame_parser
	import scfp_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    result_kind,
	output logic signed [15:0]      left_command,
	output logic signed [15:0]      right_command,
	output logic [7:0]              line_char,
	output logic                    line_last
);

	scfp_cmd_t    cmd;
	scfp_status_t st;

	scfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.st       (st),
		.cmd      (cmd)
	);

	scfp_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_kind   (result_kind),
		.left_command  (left_command),
		.right_command (right_command),
		.line_char     (line_char),
		.line_last     (line_last)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_serial_command_frame_parser.sv -----
`timescale 1ns / 1ps
// tb_serial_command_frame_parser: self-checking bench for the serial command frame parser
// streams bytes through valid/stall, predicts frames and debug lines, checks every result
// depends on scfp_pkg and serial_command_frame_parser

module tb_serial_command_frame_parser;
	import scfp_pkg::*;

	localparam int LINE_MAX = LINE_DEPTH_DEFAULT;
	localparam int QUIET_LIMIT = 5000;
	localparam int PRINT_LIMIT = 40;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 36;
	localparam logic [15:0] START_WORDS [5] = '{16'h0000, 16'hFFFF, 16'h420D, 16'h4241, 16'h0A7E};

	typedef struct packed {
		logic        kind;
		logic [15:0] left;
		logic [15:0] right;
		logic [7:0]  ch;
		logic        last;
	} parser_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [15:0] cfg_data = '0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic result_kind;
	logic signed [15:0] left_command;
	logic signed [15:0] right_command;
	logic [7:0] line_char;
	logic line_last;

	logic [7:0] byte_queue [$];
	parser_result_t pending_results [$];

	// predicted parser state
	logic [15:0] model_start;
	logic [7:0] model_frame [8];
	logic [2:0] model_pos;
	logic [7:0] model_line [LINE_MAX];
	int model_line_len;

	logic idle_on = 1'b0;
	logic hold_on = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int bytes_in = 0;
	int frames_out = 0;
	int chars_out = 0;
	int start_words = 1;
	bit run_done = 1'b0;

	serial_command_frame_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.left_command (left_command),
		.right_command(right_command),
		.line_char    (line_char),
		.line_last    (line_last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void line_feed(input logic [7:0] b);
		int n;
		if (b == CHAR_CR || b == CHAR_LF) begin
			if (model_line_len == 0)
				return;
			n = model_line_len;
			model_line[n] = CHAR_LF;
			for (int i = 0; i <= n; i++)
				pending_results.push_back(parser_result_t'{KIND_LINE, 16'h0, 16'h0,
					model_line[i], (i == n)});
			model_line_len = 0;
		end else if (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI) begin
			model_line_len = 0;
		end else if (model_line_len < LINE_MAX - 1) begin
			model_line[model_line_len] = b;
			model_line_len++;
		end else begin
			model_line_len = 0;
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [15:0] s, l, r, c;
		// wrong second start byte: held byte goes to the line, current byte hunts again
		if (model_pos == 3'd1 && b != model_start[15:8]) begin
			line_feed(model_frame[0]);
			model_pos = 3'd0;
		end
		if (model_pos == 3'd0) begin
			if (b == model_start[7:0]) begin
				model_frame[0] = b;
				model_pos = 3'd1;
			end else begin
				line_feed(b);
			end
		end else begin
			model_frame[model_pos] = b;
			if (model_pos == FRAME_LAST_POS) begin
				s = {model_frame[1], model_frame[0]};
				l = {model_frame[3], model_frame[2]};
				r = {model_frame[5], model_frame[4]};
				c = {model_frame[7], model_frame[6]};
				if (s == model_start && c == (s ^ l ^ r))
					pending_results.push_back(parser_result_t'{KIND_FRAME, l, r, 8'h00, 1'b0});
				model_pos = 3'd0;
			end else begin
				model_pos = model_pos + 3'd1;
			end
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_cmd();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_frame(input logic [15:0] s, l, r, input bit good);
		logic [15:0] c;
		logic [63:0] w;
		c = s ^ l ^ r;
		if (!good)
			c = c ^ (16'h1 << $urandom_range(0, 15));
		w = {c, r, l, s};
		for (int i = 0; i < 8; i++)
			byte_queue.push_back(w[8*i +: 8]);
	endfunction

	// printable text that never looks like a start byte, closed by CR or LF
	function automatic void add_line(input int len, input logic [7:0] avoid);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			do
				c = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
			while (c == avoid);
			byte_queue.push_back(c);
		end
		c = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
		if (c == avoid)
			c = (c == CHAR_CR) ? CHAR_LF : CHAR_CR;
		byte_queue.push_back(c);
	endfunction

	function automatic void add_traffic(input int count, input logic [15:0] sw);
		int target;
		int pick;
		logic [7:0] b;
		target = byte_queue.size() + count;
		while (byte_queue.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				add_frame(sw, rand_cmd(), rand_cmd(), 1'b1);
			end else if (pick < 45) begin
				add_frame(sw, rand_cmd(), rand_cmd(), 1'b0);
			end else if (pick < 75) begin
				add_line(($urandom_range(0, 12) == 0) ? $urandom_range(58, 66)
					: $urandom_range(0, 12), sw[7:0]);
			end else if (pick < 88) begin
				byte_queue.push_back(8'($urandom));
			end else begin
				do
					b = 8'($urandom);
				while (b == sw[15:8]);
				byte_queue.push_back(sw[7:0]);
				byte_queue.push_back(b);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
	endtask

	task automatic wait_drained(input int settle);
		while (byte_queue.size() != 0 || rx_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall) begin
				parse_byte(rx_byte);
				bytes_in++;
			end
			if (!rx_valid || !rx_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					rx_valid <= 1'b1;
					rx_byte <= byte_queue.pop_front();
					send_gap = idle_on ? pick_gap() : 0;
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		parser_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", {15'h0, result_kind}, 16'h0);
				end else begin
					want = pending_results.pop_front();
					if (result_kind !== want.kind)
						report_mismatch("result_kind", {15'h0, result_kind}, {15'h0, want.kind});
					if (left_command !== want.left)
						report_mismatch("left_command", left_command, want.left);
					if (right_command !== want.right)
						report_mismatch("right_command", right_command, want.right);
					if (line_char !== want.ch)
						report_mismatch("line_char", {8'h0, line_char}, {8'h0, want.ch});
					if (line_last !== want.last)
						report_mismatch("line_last", {15'h0, line_last}, {15'h0, want.last});
					if (want.kind == KIND_FRAME)
						frames_out++;
					else
						chars_out++;
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			result_stall <= hold_on || stall_left > 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n && !run_done) begin
			if ((rx_valid && !rx_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no item moved for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] sw;
		model_start = START_WORD_RESET;
		model_pos = 3'd0;
		model_line_len = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed bytes on the reset start word
		add_frame(START_WORD_RESET, 16'h8000, 16'h7FFF, 1'b1);
		byte_queue.push_back("H");
		byte_queue.push_back("i");
		byte_queue.push_back(CHAR_CR);
		byte_queue.push_back(CHAR_LF);
		byte_queue.push_back(START_WORD_RESET[7:0]);
		byte_queue.push_back("A");
		byte_queue.push_back(8'h01);
		add_frame(START_WORD_RESET, 16'h0000, 16'hFFFF, 1'b0);
		byte_queue.push_back(CHAR_PRINT_HI);
		byte_queue.push_back(CHAR_PRINT_LO);
		byte_queue.push_back(8'hFF);
		byte_queue.push_back(CHAR_LF);
		wait_drained(10);

		for (int p = 0; p < PHASES; p++) begin
			sw = (p < 5) ? START_WORDS[p] : 16'($urandom);
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_data <= sw;
			@(posedge clk);
			cfg_write <= 1'b0;
			model_start = sw;
			start_words++;
			idle_on <= (p % 3 != 2);
			add_traffic(PHASE_BYTES, sw);
			if (p == 3) begin
				// receiver holds off while the sender keeps offering
				add_traffic(80, sw);
				hold_on <= 1'b1;
				repeat (400) @(posedge clk);
				hold_on <= 1'b0;
			end
			// leave a frame open across the next start word change
			if (p % 4 == 1) begin
				byte_queue.push_back(sw[7:0]);
			end else if (p % 4 == 3) begin
				byte_queue.push_back(sw[7:0]);
				byte_queue.push_back(sw[15:8]);
				byte_queue.push_back(8'($urandom));
			end
			wait_drained(10);
		end
		wait_drained(40);
		run_done = 1'b1;

		$display("run sent %0d bytes under %0d start words, checked %0d frames and %0d line chars",
			bytes_in, start_words, frames_out, chars_out);
		$display("%0d mismatches", error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/scfp_pkg.sv
hdl/scfp_ctrl.sv
hdl/scfp_dp.sv
hdl/serial_command_frame_parser.sv
tb/sv/tb_serial_command_frame_parser.sv
